// ===== sv/fbwpc_pkg.sv =====
// Shared types and constants for the frame buffer pixel convert block.
`default_nettype none

package fbwpc_pkg;

  // Access kinds on the input side
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Result kinds on the output side
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Field widths fixed by the interface
  localparam int IDX_W  = 18;
  localparam int PIX_W  = IDX_W + 1;
  localparam int CFG_AW = 5;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_RED_WIDTH   = 3'd0;
  localparam logic [2:0] REG_RED_SHIFT   = 3'd1;
  localparam logic [2:0] REG_GREEN_WIDTH = 3'd2;
  localparam logic [2:0] REG_GREEN_SHIFT = 3'd3;
  localparam logic [2:0] REG_BLUE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_BLUE_SHIFT  = 3'd5;

  // Channel packing setup
  typedef struct packed {
    logic [4:0] red_width;
    logic [4:0] red_shift;
    logic [4:0] green_width;
    logic [4:0] green_shift;
    logic [4:0] blue_width;
    logic [4:0] blue_shift;
  } cfg_t;

  // What one access asks the result stage to deliver
  typedef struct packed {
    logic rd;
    logic px0;
    logic px1;
  } res_req_t;

  // One converted pixel from a lane
  typedef struct packed {
    logic [9:0]  x;
    logic [8:0]  y;
    logic [31:0] value;
  } lane_res_t;

endpackage

`default_nettype wire

// ===== sv/fbwpc_lane.sv =====
// One pixel lane: coordinate split of the pixel index and display packing.
`default_nettype none

module fbwpc_lane import fbwpc_pkg::*; #(
  parameter int WIDTH = 640
) (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [PIX_W-1:0] pix_in,
  input  wire logic             capture,
  input  wire logic [31:0]      word,
  input  wire cfg_t             cfg,
  output lane_res_t             res
);

  // Reciprocal of the row length; the estimate is low by at most one
  localparam int RECIP_SH = PIX_W + 1;
  localparam int RECIP_W  = RECIP_SH + 1;
  localparam int PROD_W   = PIX_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SH) / WIDTH);

  logic [PIX_W-1:0]  pix_r;
  logic [PIX_W-1:0]  q_r;
  logic [PROD_W-1:0] prod;
  logic [31:0]       qw;
  logic [31:0]       rem;
  logic              fix;
  logic [31:0]       x_full;
  logic [31:0]       y_full;
  lane_res_t         res_r;

  function automatic logic [31:0] pack_channel(input logic [7:0] c,
                                               input logic [4:0] w,
                                               input logic [4:0] s);
    logic [38:0] t;
    logic [31:0] v;
    t = 39'(c) << w;
    v = {1'b0, t[38:8]};
    return v << s;
  endfunction

  // Estimate the row on the transfer
  assign prod = PROD_W'(pix_in) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= pix_in;
      q_r   <= prod[RECIP_SH +: PIX_W];
    end
  end

  // Correct the row estimate and take the column as the remainder
  assign qw     = 32'(q_r) * 32'(WIDTH);
  assign rem    = 32'(pix_r) - qw;
  assign fix    = rem >= 32'(WIDTH);
  assign x_full = fix ? rem - 32'(WIDTH) : rem;
  assign y_full = fix ? 32'(q_r) + 32'd1 : 32'(q_r);

  always_ff @(posedge clk) begin
    if (capture) begin
      res_r.x     <= x_full[9:0];
      res_r.y     <= y_full[8:0];
      res_r.value <= pack_channel(word[23:16], cfg.red_width, cfg.red_shift)
                   | pack_channel(word[15:8], cfg.green_width, cfg.green_shift)
                   | pack_channel(word[7:0], cfg.blue_width, cfg.blue_shift);
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== sv/fbwpc_merge.sv =====
// Result stage: orders read data and lane pixels onto the result port.
`default_nettype none

module fbwpc_merge import fbwpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire res_req_t    req,
  input  wire logic [63:0] rd_data,
  input  wire lane_res_t   lane0,
  input  wire lane_res_t   lane1,
  output logic             more,
  output logic             out_valid,
  output logic             out_kind,
  output logic [63:0]      out_read_data,
  output logic [9:0]       out_pixel_x,
  output logic [8:0]       out_pixel_y,
  output logic [31:0]      out_pixel_value,
  output logic             out_last
);

  logic        pend_rd_r;
  logic        pend0_r;
  logic        pend1_r;
  logic [63:0] rd_data_r;

  // Load pending results, drop each one as it goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_rd_r <= 1'b0;
      pend0_r   <= 1'b0;
      pend1_r   <= 1'b0;
    end else if (load) begin
      pend_rd_r <= req.rd;
      pend0_r   <= req.px0;
      pend1_r   <= req.px1;
    end else if (pend_rd_r) begin
      pend_rd_r <= 1'b0;
    end else if (pend0_r) begin
      pend0_r <= 1'b0;
    end else begin
      pend1_r <= 1'b0;
    end
  end

  // Hold read data
  always_ff @(posedge clk) begin
    if (load) begin
      rd_data_r <= rd_data;
    end
  end

  assign more = pend0_r & pend1_r;

  // Drive the result port; upper pixel goes first
  always_comb begin
    out_valid       = 1'b0;
    out_kind        = KIND_READ;
    out_read_data   = '0;
    out_pixel_x     = '0;
    out_pixel_y     = '0;
    out_pixel_value = '0;
    out_last        = 1'b0;
    if (pend_rd_r) begin
      out_valid     = 1'b1;
      out_read_data = rd_data_r;
      out_last      = 1'b1;
    end else if (pend0_r) begin
      out_valid       = 1'b1;
      out_kind        = KIND_PIXEL;
      out_pixel_x     = lane0.x;
      out_pixel_y     = lane0.y;
      out_pixel_value = lane0.value;
      out_last        = ~pend1_r;
    end else if (pend1_r) begin
      out_valid       = 1'b1;
      out_kind        = KIND_PIXEL;
      out_pixel_x     = lane1.x;
      out_pixel_y     = lane1.y;
      out_pixel_value = lane1.value;
      out_last        = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/framebuffer_write_pixel_convert.sv =====
// Top level: frame buffer store, access control, pixel lanes and config port.
`default_nettype none

// After reset the store is swept to zero, one word per cycle, over its
// (WIDTH*HEIGHT+1)/2 words (153600 at 640x480); busy stays high during the
// sweep while config writes still go through. Every access then takes a
// read-modify-write of the single-port store: a read result passes the access
// register and the pending register of the result stage, and busy drops in the
// same cycle as it appears, so no new access is taken while one is in flight;
// writes touching both pixel halves hold busy for their second result (the
// result port carries one result per cycle). Results come as one-cycle
// out_valid strobes and cannot be held off. Two lanes convert the upper and
// lower pixel of a word side by side.
module framebuffer_write_pixel_convert import fbwpc_pkg::*; #(
  parameter int WIDTH  = 640,
  parameter int HEIGHT = 480
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_opcode,
  input  wire logic [IDX_W-1:0]  in_word_index,
  input  wire logic [63:0]       in_write_data,
  input  wire logic [7:0]        in_byte_enable,
  output logic                   out_valid,
  output logic                   out_kind,
  output logic [63:0]            out_read_data,
  output logic [9:0]             out_pixel_x,
  output logic [8:0]             out_pixel_y,
  output logic [31:0]            out_pixel_value,
  output logic                   out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int PIXELS = WIDTH * HEIGHT;
  localparam int WORDS  = (PIXELS + 1) / 2;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);

  // Configuration registers
  logic [4:0] red_width_r, red_shift_r, green_width_r, green_shift_r;
  logic [4:0] blue_width_r, blue_shift_r;
  cfg_t       cfg;
  logic       cfg_we;

  // Access control
  logic              accept;
  logic [31:0]       idx_ext;
  logic              in_rng;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  pix0, pix1;
  logic              s1_valid_r;
  logic              op_r;
  logic              rng_r;
  logic              px0_ok_r, px1_ok_r;
  logic [7:0]        be_r;
  logic [63:0]       wdata_r;
  logic [ADDR_W-1:0] addr_r;
  logic [63:0]       rdata_r;
  logic [63:0]       mask;
  logic [63:0]       word;
  logic              wr_hit;
  res_req_t          req;
  logic [63:0]       rd_data;
  logic              mrg_more;

  // Store and clearing sweep
  logic [63:0]       pixel_store [WORDS];
  logic              clr_busy_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [63:0]       mem_wdata;

  lane_res_t lane0_res, lane1_res;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_width_r   <= 5'd8;
      red_shift_r   <= 5'd16;
      green_width_r <= 5'd8;
      green_shift_r <= 5'd8;
      blue_width_r  <= 5'd8;
      blue_shift_r  <= 5'd0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_RED_WIDTH:   red_width_r   <= pwdata[4:0];
        REG_RED_SHIFT:   red_shift_r   <= pwdata[4:0];
        REG_GREEN_WIDTH: green_width_r <= pwdata[4:0];
        REG_GREEN_SHIFT: green_shift_r <= pwdata[4:0];
        REG_BLUE_WIDTH:  blue_width_r  <= pwdata[4:0];
        REG_BLUE_SHIFT:  blue_shift_r  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_RED_WIDTH:   prdata = 32'(red_width_r);
      REG_RED_SHIFT:   prdata = 32'(red_shift_r);
      REG_GREEN_WIDTH: prdata = 32'(green_width_r);
      REG_GREEN_SHIFT: prdata = 32'(green_shift_r);
      REG_BLUE_WIDTH:  prdata = 32'(blue_width_r);
      REG_BLUE_SHIFT:  prdata = 32'(blue_shift_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{red_width:   red_width_r,   red_shift:   red_shift_r,
                 green_width: green_width_r, green_shift: green_shift_r,
                 blue_width:  blue_width_r,  blue_shift:  blue_shift_r};

  // Input transfer and address decode
  assign busy    = clr_busy_r | s1_valid_r | mrg_more;
  assign accept  = start & ~busy;
  assign idx_ext = 32'(in_word_index);
  assign in_rng  = idx_ext < 32'(WORDS);
  assign rd_addr = idx_ext[ADDR_W-1:0];
  assign pix0    = {in_word_index, 1'b0};
  assign pix1    = {in_word_index, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  // Capture the access
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_opcode;
      rng_r    <= in_rng;
      px0_ok_r <= 32'(pix0) < 32'(PIXELS);
      px1_ok_r <= 32'(pix1) < 32'(PIXELS);
      be_r     <= in_byte_enable;
      wdata_r  <= in_write_data;
      addr_r   <= rd_addr;
    end
  end

  // Merge enabled bytes into the stored word
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[8*b +: 8] = {8{be_r[b]}};
    end
  end

  assign word    = (rdata_r & ~mask) | (wdata_r & mask);
  assign wr_hit  = s1_valid_r & (op_r == OP_WRITE) & rng_r & (|be_r);
  assign rd_data = rng_r ? rdata_r : '0;

  assign req.rd  = s1_valid_r & (op_r == OP_READ);
  assign req.px0 = wr_hit & (|be_r[7:4]) & px0_ok_r;
  assign req.px1 = wr_hit & (|be_r[3:0]) & px1_ok_r;

  // Sweep the store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (clr_cnt_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Store write port: sweep or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = word;
    if (clr_busy_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (wr_hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pixel_store[mem_waddr] <= mem_wdata;
    end
    if (accept && in_rng) begin
      rdata_r <= pixel_store[rd_addr];
    end
  end

  // Pixel lanes: upper half and lower half of the word
  fbwpc_lane #(.WIDTH(WIDTH)) u_lane0 (
    .clk     (clk),
    .load    (accept),
    .pix_in  (pix0),
    .capture (s1_valid_r),
    .word    (word[63:32]),
    .cfg     (cfg),
    .res     (lane0_res)
  );

  fbwpc_lane #(.WIDTH(WIDTH)) u_lane1 (
    .clk     (clk),
    .load    (accept),
    .pix_in  (pix1),
    .capture (s1_valid_r),
    .word    (word[31:0]),
    .cfg     (cfg),
    .res     (lane1_res)
  );

  // Result ordering
  fbwpc_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (s1_valid_r),
    .req             (req),
    .rd_data         (rd_data),
    .lane0           (lane0_res),
    .lane1           (lane1_res),
    .more            (mrg_more),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_read_data   (out_read_data),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_value (out_pixel_value),
    .out_last        (out_last)
  );

  // No result may leave while the store is still being swept
  a_no_out_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !out_valid)
    else $error("result strobe during store sweep");

  // A read transfer yields its read result once it has passed the access and pending registers
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_READ) |=> ##1 (out_valid && out_kind == KIND_READ && out_last))
    else $error("read result missing");

  // A read never writes the store
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && op_r == OP_READ) |-> !mem_we)
    else $error("store written during read");

endmodule

`default_nettype wire

// ===== verif/fbwpc_checker.sv =====
// Result checker for the frame buffer pixel convert block: tracks the store and predicts results.
`timescale 1ns / 1ps

module fbwpc_checker import fbwpc_pkg::*; #(
  parameter int WIDTH  = 640,
  parameter int HEIGHT = 480
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic              in_opcode,
  input  wire logic [IDX_W-1:0]  in_word_index,
  input  wire logic [63:0]       in_write_data,
  input  wire logic [7:0]        in_byte_enable,
  input  wire logic              out_valid,
  input  wire logic              out_kind,
  input  wire logic [63:0]       out_read_data,
  input  wire logic [9:0]        out_pixel_x,
  input  wire logic [8:0]        out_pixel_y,
  input  wire logic [31:0]       out_pixel_value,
  input  wire logic              out_last,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output int                     fail_count,
  output int                     pending,
  output int                     checked_count
);

  localparam int PIXELS = WIDTH * HEIGHT;
  localparam int WORDS  = (PIXELS + 1) / 2;

  typedef struct {
    logic        kind;
    logic [63:0] read_data;
    logic [9:0]  x;
    logic [8:0]  y;
    logic [31:0] value;
    logic        last;
  } fb_result_t;

  fb_result_t  expected_q[$];
  logic [63:0] word_mem[int];
  cfg_t        packing;
  int          errors   = 0;
  int          compared = 0;

  // Scale one 8-bit channel to the configured width, then move it into place
  function automatic logic [31:0] scale_channel(logic [7:0] c, logic [4:0] w, logic [4:0] s);
    logic [63:0] v;
    v = ({56'd0, c} << w) >> 8;
    return 32'(v << s);
  endfunction

  // Store content, zero where nothing was written yet or beyond the store
  function automatic logic [63:0] stored_word(int idx);
    if (idx < WORDS && word_mem.exists(idx)) return word_mem[idx];
    return '0;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    fb_result_t  want;
    fb_result_t  px_res[2];
    logic [63:0] mask;
    logic [63:0] word;
    logic [31:0] half_word;
    logic [3:0]  half_en;
    int          pix;
    int          n_px;
    if (!rst_n) begin
      word_mem.delete();
      expected_q.delete();
      packing.red_width   = 5'd8;
      packing.red_shift   = 5'd16;
      packing.green_width = 5'd8;
      packing.green_shift = 5'd8;
      packing.blue_width  = 5'd8;
      packing.blue_shift  = 5'd0;
    end else begin
      // Compare each result transfer with the oldest expectation
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: kind %0d, last %0d", out_kind, out_last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          compare_field("kind", want.kind, out_kind);
          compare_field("read_data", want.read_data, out_read_data);
          compare_field("pixel_x", want.x, out_pixel_x);
          compare_field("pixel_y", want.y, out_pixel_y);
          compare_field("pixel_value", want.value, out_pixel_value);
          compare_field("last", want.last, out_last);
          compared++;
        end
      end

      // Track register writes; unknown indexes leave the setup alone
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_RED_WIDTH:   packing.red_width   = pwdata[4:0];
          REG_RED_SHIFT:   packing.red_shift   = pwdata[4:0];
          REG_GREEN_WIDTH: packing.green_width = pwdata[4:0];
          REG_GREEN_SHIFT: packing.green_shift = pwdata[4:0];
          REG_BLUE_WIDTH:  packing.blue_width  = pwdata[4:0];
          REG_BLUE_SHIFT:  packing.blue_shift  = pwdata[4:0];
          default: ;
        endcase
      end

      // Predict the results of an accepted access
      if (start && !busy) begin
        if (in_opcode == OP_READ) begin
          want.kind      = KIND_READ;
          want.read_data = stored_word(in_word_index);
          want.x         = '0;
          want.y         = '0;
          want.value     = '0;
          want.last      = 1'b1;
          expected_q.push_back(want);
        end else if (in_word_index < WORDS && in_byte_enable != 8'd0) begin
          // Merge enabled bytes; bit 7 of the enable selects the top byte
          mask = '0;
          for (int b = 0; b < 8; b++)
            if (in_byte_enable[b]) mask[8*b +: 8] = 8'hff;
          word = (stored_word(in_word_index) & ~mask) | (in_write_data & mask);
          word_mem[in_word_index] = word;
          // Upper half first; skip untouched halves and a pixel past the end
          n_px = 0;
          for (int h = 0; h < 2; h++) begin
            pix       = 2 * int'(in_word_index) + h;
            half_word = (h == 0) ? word[63:32] : word[31:0];
            half_en   = (h == 0) ? in_byte_enable[7:4] : in_byte_enable[3:0];
            if (half_en != 4'd0 && pix < PIXELS) begin
              px_res[n_px].kind      = KIND_PIXEL;
              px_res[n_px].read_data = '0;
              px_res[n_px].x         = 10'(pix % WIDTH);
              px_res[n_px].y         = 9'(pix / WIDTH);
              px_res[n_px].value     =
                scale_channel(half_word[23:16], packing.red_width, packing.red_shift) |
                scale_channel(half_word[15:8], packing.green_width, packing.green_shift) |
                scale_channel(half_word[7:0], packing.blue_width, packing.blue_shift);
              px_res[n_px].last      = 1'b0;
              n_px++;
            end
          end
          if (n_px > 0) px_res[n_px-1].last = 1'b1;
          for (int k = 0; k < n_px; k++) expected_q.push_back(px_res[k]);
        end
      end
    end
    fail_count    <= errors;
    pending       <= expected_q.size();
    checked_count <= compared;
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top: clock, reset, access and register stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;
  import fbwpc_pkg::*;

  localparam int WIDTH        = 640;
  localparam int HEIGHT       = 480;
  localparam int WORDS        = (WIDTH * HEIGHT + 1) / 2;
  localparam int SETUPS       = 8;
  localparam int PER_SETUP    = 242;
  localparam int DRAIN_CYCLES = 8;
  // Covers the clearing sweep after reset several times over
  localparam int STALL_LIMIT  = 4 * WORDS + 20000;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam logic [2:0] REG_LIST[6] = '{REG_RED_WIDTH, REG_RED_SHIFT, REG_GREEN_WIDTH,
                                         REG_GREEN_SHIFT, REG_BLUE_WIDTH, REG_BLUE_SHIFT};
  localparam logic [4:0] RESET_VALUES[6] = '{5'd8, 5'd16, 5'd8, 5'd8, 5'd8, 5'd0};

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic              in_opcode      = OP_WRITE;
  logic [IDX_W-1:0]  in_word_index  = '0;
  logic [63:0]       in_write_data  = '0;
  logic [7:0]        in_byte_enable = '0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [CFG_AW-1:0] paddr          = '0;
  logic [31:0]       pwdata         = '0;

  logic        busy;
  logic        out_valid;
  logic        out_kind;
  logic [63:0] out_read_data;
  logic [9:0]  out_pixel_x;
  logic [8:0]  out_pixel_y;
  logic [31:0] out_pixel_value;
  logic        out_last;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int pending;
  int results_compared;
  int accesses    = 0;
  int reads       = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  framebuffer_write_pixel_convert #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_top (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_word_index, .in_write_data, .in_byte_enable,
    .out_valid, .out_kind, .out_read_data, .out_pixel_x, .out_pixel_y,
    .out_pixel_value, .out_last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  fbwpc_checker #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_checker (
    .clk, .rst_n, .start, .busy,
    .in_opcode, .in_word_index, .in_write_data, .in_byte_enable,
    .out_valid, .out_kind, .out_read_data, .out_pixel_x, .out_pixel_y,
    .out_pixel_value, .out_last,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count(mismatches), .pending, .checked_count(results_compared)
  );

  // Hold the access on the ports until the block takes it
  task automatic send_access(logic op, logic [IDX_W-1:0] idx, logic [63:0] data,
                             logic [7:0] be);
    start          <= 1'b1;
    in_opcode      <= op;
    in_word_index  <= idx;
    in_write_data  <= data;
    in_byte_enable <= be;
    @(posedge clk);
    while (busy) @(posedge clk);
    accesses++;
    if (op == OP_READ) reads++;
  endtask

  // Setup then access phase; psel stays up so writes can run back to back
  task automatic cfg_write(logic [2:0] reg_idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Drop start and wait until every predicted result has arrived
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a transfer", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    logic [4:0]       val;
    logic [IDX_W-1:0] idx;
    logic [7:0]       be;
    logic             op;
    int               sent;
    int               burst;
    int               gap;
    int               gap_max;
    int               pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < SETUPS; phase++) begin
      if (phase > 0) wait_idle();

      // Program the packing setup: defaults, then the extremes and mixed patterns, then random
      for (int i = 0; i < 6; i++) begin
        case (phase)
          0:       val = RESET_VALUES[i];
          1:       val = 5'd0;
          2:       val = 5'd31;
          3:       val = (i % 2 == 0) ? 5'd16 : 5'd0;
          4:       val = (i % 2 == 0) ? 5'd1 : 5'd31;
          default: val = 5'($urandom_range(0, 31));
        endcase
        cfg_write(REG_LIST[i], ($urandom & 32'hffff_ffe0) | 32'(val));
      end
      cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
      psel    <= 1'b0;
      penable <= 1'b0;

      // Directed accesses: corners of the store, enable patterns, row wrap
      if (phase == 0) begin
        send_access(OP_READ, 18'd0, '0, 8'h00);
        send_access(OP_WRITE, 18'd0, '1, 8'hff);
        send_access(OP_READ, 18'd0, '1, 8'hff);
        send_access(OP_WRITE, 18'd1, 64'h0011_2233_4455_6677, 8'hf0);
        send_access(OP_WRITE, 18'd1, 64'h8899_aabb_ccdd_eeff, 8'h0f);
        send_access(OP_WRITE, 18'd2, 64'hdead_beef_cafe_f00d, 8'h80);
        send_access(OP_WRITE, 18'd2, 64'h1234_5678_9abc_def0, 8'h01);
        send_access(OP_WRITE, 18'd3, '1, 8'h00);
        send_access(OP_READ, 18'd1, '0, 8'h00);
        send_access(OP_READ, 18'd2, '0, 8'h00);
        send_access(OP_READ, 18'd3, '0, 8'h00);
        send_access(OP_WRITE, 18'(WORDS - 1), {$urandom, $urandom}, 8'hff);
        send_access(OP_READ, 18'(WORDS - 1), '0, 8'h00);
        send_access(OP_WRITE, 18'(WORDS), '1, 8'hff);
        send_access(OP_READ, 18'(WORDS), '0, 8'h00);
        send_access(OP_WRITE, '1, '1, 8'hff);
        send_access(OP_READ, '1, '1, 8'hff);
        send_access(OP_WRITE, 18'(WIDTH / 2 - 1), {$urandom, $urandom}, 8'hff);
        send_access(OP_WRITE, 18'(WIDTH / 2), {$urandom, $urandom}, 8'hff);
        send_access(OP_WRITE, 18'd5, 64'haa55_aa55_55aa_55aa, 8'ha5);
        send_access(OP_READ, 18'd5, '0, 8'h00);
        send_access(OP_WRITE, 18'd0, '0, 8'hff);
      end

      // Random accesses in bursts, mostly on a small set of words
      gap_max = (phase % 3 == 0) ? 0 : 5;
      sent    = 0;
      while (sent < PER_SETUP) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && sent < PER_SETUP; k++) begin
          op   = ($urandom_range(0, 99) < 35) ? OP_READ : OP_WRITE;
          pick = $urandom_range(0, 99);
          if (pick < 60)      idx = 18'($urandom_range(0, 63));
          else if (pick < 80) idx = 18'($urandom_range(WORDS - 32, WORDS - 1));
          else if (pick < 90) idx = 18'($urandom_range(0, WORDS - 1));
          else                idx = 18'($urandom_range(0, 2**IDX_W - 1));
          pick = $urandom_range(0, 99);
          if (pick < 30)      be = 8'hff;
          else if (pick < 45) be = 8'hf0;
          else if (pick < 60) be = 8'h0f;
          else if (pick < 65) be = 8'h00;
          else                be = 8'($urandom_range(0, 255));
          send_access(op, idx, {$urandom, $urandom}, be);
          sent++;
        end
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_idle();
    $display("Covered %0d accesses (%0d reads, %0d writes) over %0d packing setups,",
             accesses, reads, accesses - reads, SETUPS);
    $display("with %0d results compared against the predicted frame buffer.",
             results_compared);
    if (mismatches == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
